// ----- sv/fpbc_pkg.sv -----
// fpbc_pkg: shared codes, plane table and unit control types for the frustum cull core
// no dependencies; used by fpbc_divsqrt and frustum_plane_box_cull_core
package fpbc_pkg;

	// command codes of the input channel
	localparam logic [1:0] CMD_LOAD_PROJ = 2'd0;
	localparam logic [1:0] CMD_LOAD_MV   = 2'd1;
	localparam logic [1:0] CMD_EXTRACT   = 2'd2;
	localparam logic [1:0] CMD_TEST      = 2'd3;

	localparam logic [2:0] LAST_PLANE = 3'd5;

	// clip column combined with column 3 for each plane
	function automatic logic [1:0] plane_col(input logic [2:0] p);
		logic [1:0] c;
		case (p)
			3'd0, 3'd1: c = 2'd0;
			3'd2, 3'd3: c = 2'd1;
			default:    c = 2'd2;
		endcase
		return c;
	endfunction

	// planes that subtract their column from column 3
	function automatic logic plane_minus(input logic [2:0] p);
		return (p == 3'd0) || (p == 3'd3) || (p == 3'd4);
	endfunction

	typedef struct packed {
		logic start;
		logic sqrt;
	} du_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} du_stat_t;

endpackage

// ----- sv/fpbc_divsqrt.sv -----
// fpbc_divsqrt: iterative restoring divider and integer square root sharing one
// compare-subtract; depends on fpbc_pkg for its control and status structs
module fpbc_divsqrt import fpbc_pkg::*; #(
	parameter int XW    = 64,
	parameter int RW    = 34,
	parameter int QW    = 48,
	parameter int NDIV  = 48,
	parameter int NSQRT = 31
) (
	input  logic            clk,
	input  logic            arst_n,
	input  du_ctrl_t        ctrl,
	input  logic [XW-1:0]   operand,
	input  logic [RW-4:0]   divisor,
	output du_stat_t        stat,
	output logic [QW-1:0]   result
);

	localparam int NMAX = (NDIV > NSQRT) ? NDIV : NSQRT;
	localparam int CW   = $clog2(NMAX + 1);

	logic          busy_q, done_q, sqrt_q;
	logic [CW-1:0] cnt_q;
	logic [XW-1:0] x_q;
	logic [RW-1:0] rem_q, dvs_q;
	logic [QW-1:0] q_q;

	logic [RW-1:0] shifted, trial;
	logic [RW:0]   diff;
	logic          ge;

	// bring down one dividend bit or two radicand bits, then try the subtract
	always_comb begin
		shifted = sqrt_q ? {rem_q[RW-3:0], x_q[XW-1 -: 2]} : {rem_q[RW-2:0], x_q[XW-1]};
		trial   = sqrt_q ? {q_q[RW-3:0], 2'b01} : dvs_q;
		diff    = {1'b0, shifted} - {1'b0, trial};
		ge      = !diff[RW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctrl.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= ctrl.sqrt ? CW'(NSQRT) : CW'(NDIV);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			sqrt_q <= ctrl.sqrt;
			x_q    <= operand;
			rem_q  <= '0;
			q_q    <= '0;
			dvs_q  <= {3'b000, divisor};
		end else if (busy_q) begin
			x_q   <= sqrt_q ? (x_q << 2) : (x_q << 1);
			rem_q <= ge ? diff[RW-1:0] : shifted;
			q_q   <= {q_q[QW-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign result    = q_q;

endmodule

// ----- sv/frustum_plane_box_cull_core.sv -----
// frustum_plane_box_cull_core: frustum plane extraction and box visibility test
// in signed fixed point; depends on fpbc_pkg and fpbc_divsqrt
//
// Commands arrive one beat at a time on the cmd channel. A load beat writes one
// projection or modelview element. An extract beat runs the sequencer: 64
// multiplies through the single shared multiplier build the clip matrix, then
// each of the six planes is formed, its normal magnitudes are shifted below
// 2^30 (one bit a cycle), squared through the multiplier, rooted in the
// bit-serial root/divide unit and its four coefficients divided one at a time.
// A test beat issues 18 multiplies (three per plane, using the worst corner
// for each axis) and raises its visible beat after the last plane is checked.
// The block is stalled while a command is in work, and also while an unread
// result blocks the output register. Stores reset to zero, so before the
// first extract every box tests invisible; a plane whose normal has zero
// length never culls.

module frustum_plane_box_cull_core import fpbc_pkg::*; #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  logic [1:0]           command,
	input  logic [3:0]           element_index,
	input  logic signed [31:0]   element_value,
	input  logic signed [31:0]   box_min_x,
	input  logic signed [31:0]   box_min_y,
	input  logic signed [31:0]   box_min_z,
	input  logic signed [31:0]   box_max_x,
	input  logic signed [31:0]   box_max_y,
	input  logic signed [31:0]   box_max_z,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic                 visible
);

	localparam int W   = WORD_BITS;
	localparam int F   = FRAC_BITS;
	localparam int PW  = 2 * W + 2;               // product of two W+1 bit operands
	localparam int AW  = W + 2;                   // exact sum of four words
	localparam int EB  = ((W > 32) ? W : 32) + 1; // input widening
	localparam int MB  = (W < 30) ? W : 30;       // normal magnitude after shift
	localparam int SB  = 2 * MB + 2;              // sum of three squares
	localparam int RB  = MB + 1;                  // root width
	localparam int RW  = RB + 3;
	localparam int N   = W + F;                   // dividend width
	localparam int XW  = (N > SB) ? N : SB;
	localparam int SHW = $clog2(W + 1);
	localparam int QW_L = N;

	// sequencer states
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CLIP  = 4'd1;
	localparam logic [3:0] S_CLIPD = 4'd2;
	localparam logic [3:0] S_PLANE = 4'd3;
	localparam logic [3:0] S_SHIFT = 4'd4;
	localparam logic [3:0] S_SQ    = 4'd5;
	localparam logic [3:0] S_SQRS  = 4'd6;
	localparam logic [3:0] S_SQRT  = 4'd7;
	localparam logic [3:0] S_DIV   = 4'd8;
	localparam logic [3:0] S_DIVW  = 4'd9;
	localparam logic [3:0] S_TEST  = 4'd10;
	localparam logic [3:0] S_TOUT  = 4'd11;

	localparam logic signed [PW-1:0] P_MAX = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [PW-1:0] P_MIN = {{(PW-W+1){1'b1}}, {(W-1){1'b0}}};
	localparam logic signed [AW-1:0] A_MAX = {3'b000, {(W-1){1'b1}}};
	localparam logic signed [AW-1:0] A_MIN = {3'b111, {(W-1){1'b0}}};
	localparam logic signed [EB-1:0] E_MAX = {{(EB-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [EB-1:0] E_MIN = {{(EB-W+1){1'b1}}, {(W-1){1'b0}}};

	// product scaled back by FRAC_BITS, floor, then clamped to the word
	function automatic logic signed [W-1:0] fx_term(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] sh;
		sh = p >>> F;
		if (sh > P_MAX) sh = P_MAX;
		else if (sh < P_MIN) sh = P_MIN;
		return sh[W-1:0];
	endfunction

	function automatic logic signed [W-1:0] sat_a(input logic signed [AW-1:0] v);
		logic signed [AW-1:0] t;
		t = v;
		if (t > A_MAX) t = A_MAX;
		else if (t < A_MIN) t = A_MIN;
		return t[W-1:0];
	endfunction

	function automatic logic signed [W-1:0] sat_in(input logic signed [31:0] v);
		logic signed [EB-1:0] e;
		e = {{(EB-32){v[31]}}, v};
		if (e > E_MAX) e = E_MAX;
		else if (e < E_MIN) e = E_MIN;
		return e[W-1:0];
	endfunction

	function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
		return v[W-1] ? (~v + W'(1)) : v;
	endfunction

	function automatic logic signed [AW-1:0] ext_a(input logic signed [W-1:0] v);
		return {{2{v[W-1]}}, v};
	endfunction

	// storage
	logic signed [W-1:0] proj_q [16];
	logic signed [W-1:0] mv_q [16];
	logic signed [W-1:0] clip_q [16];
	logic signed [W-1:0] coef_q [6][4];
	logic [5:0]          degen_q;

	logic signed [W-1:0] lo_q [3];
	logic signed [W-1:0] hi_q [3];

	// sequencer
	logic [3:0]     state_q;
	logic [5:0]     cnt_q;      // clip step: row, column, k
	logic [2:0]     p_q;        // plane in extraction
	logic [1:0]     j_q;        // coefficient being divided
	logic [1:0]     sqc_q;      // square step
	logic [SHW-1:0] sh_q;
	logic [W-1:0]   m_q [3];
	logic signed [W-1:0] cur_q [4];
	logic [SB-1:0]  sum_q;
	logic [RB-1:0]  len_q;      // normal length held for the four divides
	logic [2:0]     tp_q;       // plane in test
	logic [1:0]     ta_q;       // axis in test
	logic           cull_q;

	// shared multiplier and its tag stage
	logic signed [W:0]    mul_a, mul_b;
	logic signed [PW-1:0] prod_s1;
	logic                 iss_s1;
	logic [1:0]           tagk_s1;
	logic [3:0]           tagi_s1;
	logic signed [AW-1:0] acc_q;

	logic                 res_valid_q, visible_q;

	// root/divide unit
	du_ctrl_t       du_ctrl;
	du_stat_t       du_stat;
	logic [XW-1:0]  du_operand;
	logic [QW_L-1:0] du_result;

	logic cmd_acc, res_acc;
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign res_acc   = res_valid_q && !res_stall;
	assign cmd_stall = (state_q != S_IDLE) || (res_valid_q && res_stall);
	assign res_valid = res_valid_q;
	assign visible   = visible_q;

	// plane candidates from clip column 3 and the plane's own column
	logic signed [W-1:0] pc [4];
	logic [1:0]          pcol;
	always_comb begin
		pcol = plane_col(p_q);
		for (int j = 0; j < 4; j++) begin
			if (plane_minus(p_q))
				pc[j] = sat_a(ext_a(clip_q[4'(j * 4 + 3)]) - ext_a(clip_q[{2'(j), pcol}]));
			else
				pc[j] = sat_a(ext_a(clip_q[4'(j * 4 + 3)]) + ext_a(clip_q[{2'(j), pcol}]));
		end
	end

	// worst corner for the current test axis: larger end for a positive coefficient
	logic signed [W-1:0] tcoef, corner, big, lit;
	always_comb begin
		tcoef  = coef_q[tp_q][ta_q];
		big    = (hi_q[ta_q] > lo_q[ta_q]) ? hi_q[ta_q] : lo_q[ta_q];
		lit    = (hi_q[ta_q] > lo_q[ta_q]) ? lo_q[ta_q] : hi_q[ta_q];
		corner = tcoef[W-1] ? lit : big;
	end

	// multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_CLIP: begin
				mul_a = {mv_q[{cnt_q[5:4], cnt_q[1:0]}][W-1], mv_q[{cnt_q[5:4], cnt_q[1:0]}]};
				mul_b = {proj_q[{cnt_q[1:0], cnt_q[3:2]}][W-1], proj_q[{cnt_q[1:0], cnt_q[3:2]}]};
			end
			S_SQ: begin
				if (sqc_q != 2'd3) begin
					mul_a = {1'b0, m_q[sqc_q]};
					mul_b = {1'b0, m_q[sqc_q]};
				end
			end
			S_TEST: begin
				mul_a = {tcoef[W-1], tcoef};
				mul_b = {corner[W-1], corner};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// accumulate side of the multiplier
	logic signed [W-1:0]  term;
	logic signed [AW-1:0] acc_base, acc_nxt;
	logic                 cull_nxt;
	logic                 in_test;
	always_comb begin
		term    = fx_term(prod_s1);
		in_test = (state_q == S_TEST) || (state_q == S_TOUT);
		if (tagk_s1 == 2'd0)
			acc_base = in_test ? ext_a(coef_q[tagi_s1[2:0]][3]) : '0;
		else
			acc_base = acc_q;
		acc_nxt  = acc_base + ext_a(term);
		cull_nxt = cull_q;
		// plane culls when its best corner is on or behind it
		if (in_test && iss_s1 && tagk_s1 == 2'd2 && !degen_q[tagi_s1[2:0]] &&
		    (acc_nxt[AW-1] || acc_nxt == '0))
			cull_nxt = 1'b1;
	end

	// root and divide operands
	logic [W-1:0] magsh;
	logic [N-1:0] dividend;
	logic [RB-1:0] root;
	logic         shift_more;
	logic         dneg;
	logic [N-1:0] dlim, dq;
	logic [W-1:0] dres;
	always_comb begin
		magsh      = mag(cur_q[j_q]) >> sh_q;
		dividend   = {magsh, {F{1'b0}}};
		root       = du_result[RB-1:0];
		shift_more = ((m_q[0] >> 30) != '0) || ((m_q[1] >> 30) != '0) ||
		             ((m_q[2] >> 30) != '0);
		dneg       = cur_q[j_q][W-1];
		dlim       = dneg ? N'({1'b1, {(W-1){1'b0}}}) : N'({(W-1){1'b1}});
		dq         = (du_result > dlim) ? dlim : du_result;
		dres       = dneg ? (~dq[W-1:0] + W'(1)) : dq[W-1:0];
		du_ctrl.start = (state_q == S_SQRS) || (state_q == S_DIV);
		du_ctrl.sqrt  = (state_q == S_SQRS);
		du_operand    = (state_q == S_SQRS) ? (XW'(sum_q) << (XW - SB))
		                                    : (XW'(dividend) << (XW - N));
	end

	fpbc_divsqrt #(
		.XW    (XW),
		.RW    (RW),
		.QW    (QW_L),
		.NDIV  (N),
		.NSQRT (RB)
	) u_divsqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (du_ctrl),
		.operand (du_operand),
		.divisor (len_q),
		.stat    (du_stat),
		.result  (du_result)
	);

	// multiplier register and its tags
	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		tagk_s1 <= (state_q == S_CLIP) ? cnt_q[1:0] : ta_q;
		tagi_s1 <= (state_q == S_CLIP) ? cnt_q[5:2] : {1'b0, tp_q};
		if (iss_s1) begin
			acc_q <= acc_nxt;
			if (!in_test && tagk_s1 == 2'd3)
				clip_q[tagi_s1] <= sat_a(acc_nxt);
		end
	end

	// datapath registers of the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (cmd_acc && command == CMD_TEST) begin
					lo_q[0] <= sat_in(box_min_x);
					lo_q[1] <= sat_in(box_min_y);
					lo_q[2] <= sat_in(box_min_z);
					hi_q[0] <= sat_in(box_max_x);
					hi_q[1] <= sat_in(box_max_y);
					hi_q[2] <= sat_in(box_max_z);
				end
			end
			S_PLANE: begin
				for (int j = 0; j < 4; j++) cur_q[j] <= pc[j];
				for (int i = 0; i < 3; i++) m_q[i] <= mag(pc[i]);
				sh_q <= '0;
			end
			S_SHIFT: begin
				if (shift_more) begin
					for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
					sh_q <= sh_q + SHW'(1);
				end else begin
					sum_q <= '0;
				end
			end
			S_SQ: begin
				if (sqc_q != 2'd0) sum_q <= sum_q + prod_s1[SB-1:0];
			end
			S_SQRT: begin
				if (du_stat.done) len_q <= root;
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			p_q         <= '0;
			j_q         <= '0;
			sqc_q       <= '0;
			tp_q        <= '0;
			ta_q        <= '0;
			cull_q      <= 1'b0;
			iss_s1      <= 1'b0;
			res_valid_q <= 1'b0;
			visible_q   <= 1'b0;
			degen_q     <= '0;
			for (int i = 0; i < 16; i++) begin
				proj_q[i] <= '0;
				mv_q[i]   <= '0;
			end
			for (int p = 0; p < 6; p++)
				for (int j = 0; j < 4; j++) coef_q[p][j] <= '0;
		end else begin
			iss_s1 <= (state_q == S_CLIP) || (state_q == S_TEST);
			// cull flag starts clear for every test
			cull_q <= (state_q == S_IDLE) ? 1'b0 : cull_nxt;
			if (res_acc) res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd_acc) begin
						case (command)
							CMD_LOAD_PROJ: proj_q[element_index] <= sat_in(element_value);
							CMD_LOAD_MV:   mv_q[element_index] <= sat_in(element_value);
							CMD_EXTRACT: begin
								cnt_q   <= '0;
								state_q <= S_CLIP;
							end
							default: begin
								tp_q    <= '0;
								ta_q    <= '0;
								state_q <= S_TEST;
							end
						endcase
					end
				end
				S_CLIP: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) state_q <= S_CLIPD;
				end
				S_CLIPD: begin
					p_q     <= '0;
					state_q <= S_PLANE;
				end
				S_PLANE: begin
					for (int j = 0; j < 4; j++) coef_q[p_q][j] <= pc[j];
					state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					if (!shift_more) begin
						sqc_q   <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					sqc_q <= sqc_q + 2'd1;
					if (sqc_q == 2'd3) state_q <= S_SQRS;
				end
				S_SQRS: state_q <= S_SQRT;
				S_SQRT: begin
					if (du_stat.done) begin
						if (root == '0) begin
							degen_q[p_q] <= 1'b1;
							if (p_q == LAST_PLANE) begin
								state_q <= S_IDLE;
							end else begin
								p_q     <= p_q + 3'd1;
								state_q <= S_PLANE;
							end
						end else begin
							degen_q[p_q] <= 1'b0;
							j_q          <= '0;
							state_q      <= S_DIV;
						end
					end
				end
				S_DIV: state_q <= S_DIVW;
				S_DIVW: begin
					if (du_stat.done) begin
						coef_q[p_q][j_q] <= dres;
						j_q <= j_q + 2'd1;
						if (j_q != 2'd3) begin
							state_q <= S_DIV;
						end else if (p_q == LAST_PLANE) begin
							state_q <= S_IDLE;
						end else begin
							p_q     <= p_q + 3'd1;
							state_q <= S_PLANE;
						end
					end
				end
				S_TEST: begin
					if (ta_q == 2'd2) begin
						ta_q <= '0;
						tp_q <= tp_q + 3'd1;
						if (tp_q == LAST_PLANE) state_q <= S_TOUT;
					end else begin
						ta_q <= ta_q + 2'd1;
					end
				end
				S_TOUT: begin
					visible_q   <= !cull_nxt;
					res_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_res_from_test: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q) == S_TOUT)
		else $error("result beat raised outside the end of a box test");

	a_du_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		du_ctrl.start |-> !du_stat.busy)
		else $error("root/divide unit started while busy");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !cmd_acc) |=> state_q == S_IDLE)
		else $error("sequencer left idle without a command beat");
`endif

endmodule

// ----- bench/frustum_plane_box_cull_core_tb.sv -----
// frustum_plane_box_cull_core_tb: self-checking bench for the frustum cull core
// drives load, extract and box-test beats, predicts each visible beat in a scoreboard
// depends on fpbc_pkg and frustum_plane_box_cull_core
module frustum_plane_box_cull_core_tb import fpbc_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  FRAC          = 16;
	localparam longint WORD_MAX   = 64'sd2147483647;
	localparam longint WORD_MIN   = -64'sd2147483648;
	localparam longint ONE        = 64'sd65536;
	localparam int  CYCLE_LIMIT   = 1500000;
	localparam int  RANDOM_FRAMES = 45;

	// predicts the visible beats from its own copy of the matrices and planes
	class cull_scoreboard;
		longint proj_elem[16];
		longint mview_elem[16];
		longint plane_co[24];
		bit     plane_flat[6];
		bit     visible_q[$];
		int     errors;

		function new();
			foreach (proj_elem[i]) begin
				proj_elem[i]  = 0;
				mview_elem[i] = 0;
			end
			foreach (plane_co[i]) plane_co[i] = 0;
			foreach (plane_flat[i]) plane_flat[i] = 0;
			errors = 0;
		endfunction

		function longint clamp_word(longint v);
			if (v > WORD_MAX) return WORD_MAX;
			if (v < WORD_MIN) return WORD_MIN;
			return v;
		endfunction

		// product floored to the fraction point, then clamped
		function longint fx_mul(longint a, longint b);
			longint p;
			p = a * b;
			p = p >>> FRAC;
			return clamp_word(p);
		endfunction

		function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		function longint unsigned magnitude(longint v);
			return (v < 0) ? longint'(-v) : longint'(v);
		endfunction

		function longint unit_div(longint v, int s, longint unsigned len);
			longint unsigned m, lim, q, rem, r;
			m   = magnitude(v) >> s;
			lim = (v < 0) ? 64'd2147483648 : 64'd2147483647;
			q   = m / len;
			rem = m % len;
			if (q > (lim >> FRAC)) begin
				r = lim;
			end else begin
				r = (q << FRAC) + ((rem << FRAC) / len);
				if (r > lim) r = lim;
			end
			return (v < 0) ? -longint'(r) : longint'(r);
		endfunction

		function void normalize_plane(int p);
			longint unsigned m0, m1, m2, mx, len;
			int s;
			m0 = magnitude(plane_co[p*4]);
			m1 = magnitude(plane_co[p*4+1]);
			m2 = magnitude(plane_co[p*4+2]);
			mx = m0;
			if (m1 > mx) mx = m1;
			if (m2 > mx) mx = m2;
			s = 0;
			while ((mx >> s) >= (64'd1 << 30)) s++;
			m0 >>= s;
			m1 >>= s;
			m2 >>= s;
			len = int_sqrt(m0*m0 + m1*m1 + m2*m2);
			if (len == 0) begin
				plane_flat[p] = 1;
				return;
			end
			plane_flat[p] = 0;
			for (int i = 0; i < 4; i++) plane_co[p*4+i] = unit_div(plane_co[p*4+i], s, len);
		endfunction

		function void extract_planes();
			longint clip[16];
			longint acc, base, other;
			for (int r = 0; r < 4; r++)
				for (int c = 0; c < 4; c++) begin
					acc = 0;
					for (int k = 0; k < 4; k++)
						acc += fx_mul(mview_elem[r*4+k], proj_elem[k*4+c]);
					clip[r*4+c] = clamp_word(acc);
				end
			for (int p = 0; p < 6; p++) begin
				for (int j = 0; j < 4; j++) begin
					base  = clip[j*4+3];
					other = clip[j*4+plane_col(3'(p))];
					plane_co[p*4+j] = clamp_word(plane_minus(3'(p)) ? base - other : base + other);
				end
				normalize_plane(p);
			end
		endfunction

		function bit box_visible(longint lo[3], longint hi[3]);
			longint x, y, z, dot;
			bit behind;
			for (int p = 0; p < 6; p++) begin
				if (plane_flat[p]) continue;
				behind = 1;
				for (int k = 0; k < 8; k++) begin
					x = k[0] ? hi[0] : lo[0];
					y = k[1] ? hi[1] : lo[1];
					z = k[2] ? hi[2] : lo[2];
					dot = fx_mul(plane_co[p*4], x) + fx_mul(plane_co[p*4+1], y)
						+ fx_mul(plane_co[p*4+2], z) + plane_co[p*4+3];
					if (dot > 0) behind = 0;
				end
				if (behind) return 0;
			end
			return 1;
		endfunction

		function void note_beat(logic [1:0] cmd, logic [3:0] idx, logic signed [31:0] val,
				longint lo[3], longint hi[3]);
			case (cmd)
				CMD_LOAD_PROJ: proj_elem[idx]  = longint'(val);
				CMD_LOAD_MV:   mview_elem[idx] = longint'(val);
				CMD_EXTRACT:   extract_planes();
				default:       visible_q.push_back(box_visible(lo, hi));
			endcase
		endfunction

		function void check_visible(logic v);
			bit want;
			if (visible_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected visible beat: %b", v);
				return;
			end
			want = visible_q.pop_front();
			if (v !== want) begin
				errors++;
				if (errors <= 10) $display("visible mismatch: expected %b actual %b", want, v);
			end
		endfunction
	endclass

	logic               clk = 0;
	logic               arst_n = 0;
	logic               cmd_valid = 0;
	logic               cmd_stall;
	logic [1:0]         command = CMD_LOAD_PROJ;
	logic [3:0]         element_index = 0;
	logic signed [31:0] element_value = 0;
	logic signed [31:0] box_min_x = 0, box_min_y = 0, box_min_z = 0;
	logic signed [31:0] box_max_x = 0, box_max_y = 0, box_max_z = 0;
	logic               res_valid;
	logic               res_stall = 1;
	logic               visible;

	cull_scoreboard sb = new();
	bit  long_hold;      // asks the receiver for one long hold-off
	bit  no_gaps;        // sender burst mode, no idle cycles
	int  cycles;

	frustum_plane_box_cull_core dut (.*);

	always #5 clk = ~clk;

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// result side: every accepted visible beat is checked in order
	always @(posedge clk)
		if (arst_n && res_valid && !res_stall) sb.check_visible(visible);

	// receiver: random stall per beat, bursts without stall, one long hold-off on request
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				n = 400;
				long_hold = 0;
			end else if ($urandom_range(0, 3) == 0) begin
				n = 0;
			end else begin
				n = $urandom_range(0, 15);
			end
			repeat (n) begin
				@(negedge clk);
				res_stall = 1;
			end
			@(negedge clk);
			res_stall = 0;
			do @(posedge clk); while (!res_valid);
		end
	end

	// one beat on the cmd channel; idle cycles first, then hold until taken
	task automatic send_beat(logic [1:0] cmd, logic [3:0] idx, logic signed [31:0] val,
			logic signed [31:0] lx, ly, lz, hx, hy, hz);
		int gap;
		longint lo[3], hi[3];
		gap = no_gaps ? 0 : $urandom_range(0, 15);
		repeat (gap) begin
			@(negedge clk);
			cmd_valid = 0;
		end
		@(negedge clk);
		command = cmd;
		element_index = idx;
		element_value = val;
		box_min_x = lx; box_min_y = ly; box_min_z = lz;
		box_max_x = hx; box_max_y = hy; box_max_z = hz;
		cmd_valid = 1;
		do @(posedge clk); while (cmd_stall);
		lo = '{longint'(lx), longint'(ly), longint'(lz)};
		hi = '{longint'(hx), longint'(hy), longint'(hz)};
		sb.note_beat(cmd, idx, val, lo, hi);
	endtask

	// load beats carry random box fields so those bits toggle too
	task automatic load_elem(logic [1:0] cmd, logic [3:0] idx, logic signed [31:0] val);
		send_beat(cmd, idx, val, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic test_box(logic signed [31:0] lx, ly, lz, hx, hy, hz);
		send_beat(CMD_TEST, 4'($urandom), $urandom, lx, ly, lz, hx, hy, hz);
	endtask

	task automatic extract();
		load_elem(CMD_EXTRACT, 4'($urandom), $urandom);
	endtask

	// matrix content: mostly plausible transforms, some extremes and noise
	function automatic logic signed [31:0] rand_elem();
		case ($urandom_range(0, 7))
			0:       return 0;
			1:       return 32'(ONE);
			2:       return $urandom;
			3:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return $signed($urandom_range(0, 8 << FRAC)) - (4 << FRAC);
		endcase
	endfunction

	function automatic logic signed [31:0] rand_coord();
		return ($urandom_range(0, 5) == 0) ? $urandom
			: $signed($urandom_range(0, 8 << FRAC)) - (4 << FRAC);
	endfunction

	task automatic random_box();
		logic signed [31:0] c[3], h[3];
		for (int i = 0; i < 3; i++) begin
			c[i] = rand_coord();
			h[i] = $urandom_range(0, 2 << FRAC);
			// occasionally an inverted box, min above max
			if ($urandom_range(0, 9) == 0) h[i] = -h[i];
		end
		test_box(c[0] - h[0], c[1] - h[1], c[2] - h[2], c[0] + h[0], c[1] + h[1], c[2] + h[2]);
	endtask

	initial begin
		cycles = 0;
		long_hold = 0;
		no_gaps = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: planes all zero after reset, so any box is invisible
		test_box(0, 0, 0, 0, 0, 0);
		test_box(32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		// zero matrices give zero-length normals, so nothing culls
		extract();
		test_box(0, 0, 0, 0, 0, 0);
		// identity in both stores: unit cube frustum
		for (int i = 0; i < 4; i++) begin
			load_elem(CMD_LOAD_PROJ, 4'(i*5), 32'(ONE));
			load_elem(CMD_LOAD_MV, 4'(i*5), 32'(ONE));
		end
		extract();
		test_box(-32'sd32768, -32'sd32768, -32'sd32768, 32'sd32768, 32'sd32768, 32'sd32768);
		test_box(32'(2*ONE), 0, 0, 32'(3*ONE), 32'sd1, 32'sd1);
		test_box(32'(ONE), 0, 0, 32'(2*ONE), 0, 0);
		test_box(32'(3*ONE), 0, 0, -32'(3*ONE), 0, 0);
		// saturating extremes through the multiplier and the sums
		load_elem(CMD_LOAD_PROJ, 4'd3, 32'sh7fffffff);
		load_elem(CMD_LOAD_MV, 4'd12, 32'sh80000000);
		load_elem(CMD_LOAD_PROJ, 4'd15, 32'sh80000000);
		extract();
		test_box(32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		test_box(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);

		// random frames: a few element updates, usually an extract, then a run of box tests
		for (int f = 0; f < RANDOM_FRAMES; f++) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(1, 4))
				load_elem($urandom_range(0, 1) ? CMD_LOAD_MV : CMD_LOAD_PROJ,
					4'($urandom), rand_elem());
			if ($urandom_range(0, 7) != 0) extract();
			// one frame holds the receiver off while tests stream in back to back
			if (f == RANDOM_FRAMES / 2) begin
				long_hold = 1;
				no_gaps = 1;
				repeat (30) random_box();
			end
			repeat ($urandom_range(4, 10)) random_box();
		end
		no_gaps = 0;

		@(negedge clk);
		cmd_valid = 0;
		while (sb.visible_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.visible_q.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
